@@ sv/bip_pkg.sv @@
// Shared types and constants of the binarize and isolated-pixel filter.
package bip_pkg;

    // Default frame limits
    localparam int unsigned DEF_MAX_WIDTH  = 128;
    localparam int unsigned DEF_MAX_HEIGHT = 128;

    // Smallest frame side in use
    localparam logic [7:0] MIN_SIDE = 8'd3;

    // Register indexes on paddr[3:2]
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    // Register reset values
    localparam logic [7:0] RST_THRESHOLD = 8'd128;
    localparam logic [7:0] RST_WIDTH     = 8'd128;
    localparam logic [7:0] RST_HEIGHT    = 8'd128;

    // Input word kinds carried on s_tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Upper and middle line bits of one column
    typedef struct packed {
        logic u;
        logic m;
    } t_col_bits;

    // Controls broadcast to every cell of the line ring
    typedef struct packed {
        logic       shift;     // rotate ring one column toward the head
        logic       cell_wr;   // write the new bit into the cell at wr_idx
        logic       tail_wr;   // write the new bit into the tail column
        logic       wr_bit;    // binarized pixel being written
        logic [7:0] wr_idx;    // cell offset from the head column
        logic [7:0] wrap_idx;  // last active cell, frame width minus two
    } t_ring_ctl;

    // Window taps around the column being decided
    typedef struct packed {
        t_col_bits head;    // column being decided
        logic      next_m;  // middle bit one column right
        t_col_bits tail;    // column one to the left
    } t_ring_taps;

endpackage

@@ sv/bip_cell.sv @@
// One column cell of the line ring: holds upper and middle bits of a column.
module bip_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bip_pkg::t_ring_ctl  i_ctl,
    input  bip_pkg::t_col_bits  i_nb,
    input  bip_pkg::t_col_bits  i_tail,
    output bip_pkg::t_col_bits  o_bits
);
    import bip_pkg::*;

    t_col_bits r_bits;
    t_col_bits n_bits;
    logic      active;
    logic      wrap;
    logic      sel;

    // Decode this cell's place in the ring
    assign active = (8'(IDX) <= i_ctl.wrap_idx);
    assign wrap   = (8'(IDX) == i_ctl.wrap_idx);
    assign sel    = i_ctl.cell_wr && (i_ctl.wr_idx == 8'(IDX));

    // Rotate from the neighbor, or push the new bit down the column
    always_comb begin
        n_bits = r_bits;
        if (i_ctl.shift && active) begin
            n_bits = wrap ? i_tail : i_nb;
        end else if (sel) begin
            n_bits.u = r_bits.m;
            n_bits.m = i_ctl.wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else begin
            r_bits <= n_bits;
        end
    end

    assign o_bits = r_bits;

endmodule

@@ sv/bip_ring.sv @@
// Line ring: a chain of column cells plus the tail column left of the head.
module bip_ring #(
    parameter int unsigned MAX_WIDTH = bip_pkg::DEF_MAX_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bip_pkg::t_ring_ctl  i_ctl,
    output bip_pkg::t_ring_taps o_taps
);
    import bip_pkg::*;

    localparam int unsigned NC = MAX_WIDTH - 1;

    t_col_bits w_bits [NC];
    t_col_bits r_tail;
    t_col_bits n_tail;

    // Chain of cells, each fed by its right neighbor
    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        t_col_bits w_nb;
        if (gi == NC - 1) begin : g_last
            assign w_nb = r_tail;
        end else begin : g_mid
            assign w_nb = w_bits[gi + 1];
        end
        bip_cell #(
            .IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_nb    (w_nb),
            .i_tail  (r_tail),
            .o_bits  (w_bits[gi])
        );
    end

    // Take the head column on rotate, or push the new bit into the tail
    always_comb begin
        n_tail = r_tail;
        if (i_ctl.shift) begin
            n_tail = w_bits[0];
            if (i_ctl.cell_wr && (i_ctl.wr_idx == 8'd0)) begin
                n_tail.u = w_bits[0].m;
                n_tail.m = i_ctl.wr_bit;
            end
        end else if (i_ctl.tail_wr) begin
            n_tail.u = r_tail.m;
            n_tail.m = i_ctl.wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= '0;
        end else begin
            r_tail <= n_tail;
        end
    end

    // Fixed taps around the head column
    assign o_taps.head   = w_bits[0];
    assign o_taps.next_m = w_bits[1].m;
    assign o_taps.tail   = r_tail;

endmodule

@@ sv/binarize_isolated_pixel_removal.sv @@
// Top level: threshold binarization with isolated white pixel removal.
//
// Input stream: one word per pixel or drain tick. s_tdata holds the grey
// level, s_tuser the kind (pixel or drain). Output stream: one word per
// filtered pixel with its row and column, m_tlast on the frame's last pixel.
// Pixels arrive in raster order; a pixel is decided once the pixel below it
// arrives, then waits in a holding register, so a pixel's result leaves as a
// side effect of the word one row plus one pixel later, and is registered in
// the output or skid register as that word is accepted. After the last pixel
// of a frame, the clamped frame width plus one drain ticks flush the last row
// and the held pixel. Throughput is one word per cycle while s_tready is high;
// the ring of column cells decides one pixel and rotates one column per cycle.
// The output register and a skid register part the two sides: s_tready
// drops only while both hold an untaken word, so a stalled receiver stops
// the input after two pending results.
// APB registers: threshold, frame_width, frame_height at 0x0, 0x4, 0x8.
// Writing a frame size restarts the stream positions and empties the held
// pixel. Reset clears positions, line bits and output words and loads the
// register defaults; no clearing pass follows reset.
module binarize_isolated_pixel_removal #(
    parameter int unsigned MAX_WIDTH  = bip_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bip_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_value
    input  logic        s_tuser,   // [0] command
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] bit_pixel, [7:1] out_row, [14:8] out_column
    output logic        m_tlast,   // end_of_frame
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bip_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned PW = $clog2(MAX_WIDTH + 1);
    localparam logic [7:0]  MAXW8 = 8'(MAX_WIDTH);
    localparam logic [7:0]  MAXH8 = 8'(MAX_HEIGHT);

    // Configuration registers
    logic [7:0] r_threshold;
    logic [7:0] r_frame_width;
    logic [7:0] r_frame_height;
    logic       cfg_wr;
    logic       restart;
    logic [7:0] w8;
    logic [7:0] h8;

    // Stream position state
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic [PW-1:0] r_pending, n_pending;
    logic          r_hold_v,  n_hold_v;
    logic          r_hold_bit, n_hold_bit;
    logic [CW-1:0] r_hold_col, n_hold_col;
    logic [RW-1:0] r_hold_row, n_hold_row;

    // Output register and skid register
    logic          r_obuf_v, n_obuf_v;
    logic          r_skid_v, n_skid_v;
    logic [15:0]   r_obuf_word, n_obuf_word;
    logic          r_obuf_last, n_obuf_last;
    logic [15:0]   r_skid_word, n_skid_word;
    logic          r_skid_last, n_skid_last;

    // Per-word decode
    logic       in_acc;
    logic       is_pix;
    logic       b;
    logic       full;
    logic       drain_work;
    logic       decide;
    logic       emit;
    logic       push;
    logic       pop;
    logic       up, down, left, right, v;
    logic       eof;
    logic [15:0] emit_word;
    logic [7:0] in_col8, in_row8, out_col8, out_row8, pend8;

    t_ring_ctl  ring_ctl;
    t_ring_taps taps;

    // Clamp the frame sides into the supported range
    assign w8 = (r_frame_width  < MIN_SIDE) ? MIN_SIDE :
                (r_frame_width  > MAXW8)    ? MAXW8 : r_frame_width;
    assign h8 = (r_frame_height < MIN_SIDE) ? MIN_SIDE :
                (r_frame_height > MAXH8)    ? MAXH8 : r_frame_height;

    // APB write and read
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign restart = cfg_wr && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT));

    always_comb begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = {24'd0, r_threshold};
            REG_WIDTH:     prdata = {24'd0, r_frame_width};
            REG_HEIGHT:    prdata = {24'd0, r_frame_height};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= RST_THRESHOLD;
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_THRESHOLD: r_threshold    <= pwdata[7:0];
                REG_WIDTH:     r_frame_width  <= pwdata[7:0];
                REG_HEIGHT:    r_frame_height <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Decode the accepted word
    assign s_tready = !r_skid_v;
    assign in_acc   = s_tvalid && s_tready;
    assign is_pix   = (s_tuser == CMD_PIXEL);
    assign b        = (s_tdata > r_threshold);

    assign in_col8  = 8'(r_in_col);
    assign in_row8  = 8'(r_in_row);
    assign out_col8 = 8'(r_out_col);
    assign out_row8 = 8'(r_out_row);
    assign pend8    = 8'(r_pending);

    assign full       = (pend8 >= w8);
    assign drain_work = !is_pix && (pend8 != 8'd0) && (in_row8 == 8'd0) &&
                        (out_row8 == h8 - 8'd1);
    assign decide     = (is_pix && full) || drain_work;

    // Cross window around the head column
    assign up    = (out_row8 != 8'd0) && taps.head.u;
    assign left  = (out_col8 != 8'd0) && (full ? taps.tail.u : taps.tail.m);
    assign right = (out_col8 + 8'd1 < w8) && taps.next_m;
    assign down  = is_pix && (out_row8 + 8'd1 < h8) && b;
    assign v     = taps.head.m && (up || down || left || right);

    // Drive the line ring
    always_comb begin
        ring_ctl.shift    = in_acc && decide;
        ring_ctl.cell_wr  = in_acc && is_pix && !(!full && (pend8 == w8 - 8'd1));
        ring_ctl.tail_wr  = in_acc && is_pix && !full && (pend8 == w8 - 8'd1);
        ring_ctl.wr_bit   = b;
        ring_ctl.wr_idx   = full ? 8'd0 : pend8;
        ring_ctl.wrap_idx = w8 - 8'd2;
    end

    bip_ring #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .o_taps  (taps)
    );

    // Advance positions, pending count and the held pixel
    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_pending  = r_pending;
        n_hold_v   = r_hold_v;
        n_hold_bit = r_hold_bit;
        n_hold_col = r_hold_col;
        n_hold_row = r_hold_row;
        if (restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_pending = '0;
            n_hold_v  = 1'b0;
        end else if (in_acc) begin
            if (is_pix) begin
                if (in_col8 + 8'd1 >= w8) begin
                    n_in_col = '0;
                    n_in_row = (in_row8 + 8'd1 >= h8) ? '0 : r_in_row + RW'(1);
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
                if (!full) begin
                    n_pending = r_pending + PW'(1);
                end
            end else if (drain_work) begin
                n_pending = r_pending - PW'(1);
            end
            if (decide) begin
                n_hold_v   = 1'b1;
                n_hold_bit = v;
                n_hold_col = r_out_col;
                n_hold_row = r_out_row;
                if (out_col8 + 8'd1 >= w8) begin
                    n_out_col = '0;
                    n_out_row = (out_row8 + 8'd1 >= h8) ? '0 : r_out_row + RW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end else if (!is_pix) begin
                n_hold_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
            r_hold_v  <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pending <= n_pending;
            r_hold_v  <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_bit <= n_hold_bit;
        r_hold_col <= n_hold_col;
        r_hold_row <= n_hold_row;
    end

    // Release the held pixel
    assign emit      = r_hold_v && (decide || !is_pix);
    assign push      = in_acc && emit;
    assign pop       = r_obuf_v && m_tready;
    assign eof       = (8'(r_hold_row) == h8 - 8'd1) && (8'(r_hold_col) == w8 - 8'd1);
    assign emit_word = {1'b0, 7'(r_hold_col), 7'(r_hold_row), r_hold_bit};

    // Output register with skid behind it
    always_comb begin
        n_obuf_v    = r_obuf_v;
        n_skid_v    = r_skid_v;
        n_obuf_word = r_obuf_word;
        n_obuf_last = r_obuf_last;
        n_skid_word = r_skid_word;
        n_skid_last = r_skid_last;
        if (pop) begin
            if (r_skid_v) begin
                n_obuf_word = r_skid_word;
                n_obuf_last = r_skid_last;
                n_skid_v    = 1'b0;
            end else begin
                n_obuf_v = 1'b0;
            end
        end
        if (push) begin
            if (!n_obuf_v) begin
                n_obuf_word = emit_word;
                n_obuf_last = eof;
                n_obuf_v    = 1'b1;
            end else begin
                n_skid_word = emit_word;
                n_skid_last = eof;
                n_skid_v    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obuf_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_obuf_v <= n_obuf_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obuf_word <= n_obuf_word;
        r_obuf_last <= n_obuf_last;
        r_skid_word <= n_skid_word;
        r_skid_last <= n_skid_last;
    end

    assign m_tvalid = r_obuf_v;
    assign m_tdata  = r_obuf_word;
    assign m_tlast  = r_obuf_last;

`ifndef SYNTHESIS
    // Pending pixels never exceed one row
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend8 <= w8)
        else $error("pending count above frame width");

    // Output column stays inside the frame
    a_out_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_col8 < w8)
        else $error("output column outside frame");

    // Skid word only behind a full output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_obuf_v)
        else $error("skid register holds a word ahead of the output register");

    // A decision over a held pixel shows a result next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && decide && r_hold_v && !restart) |=> m_tvalid)
        else $error("released pixel did not reach the output");
`endif

endmodule

@@ test/binarize_isolated_pixel_removal_test.sv @@
// Self-checking testbench of the binarize and isolated-pixel filter stream block.
module binarize_isolated_pixel_removal_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bip_pkg::*;

    localparam int unsigned MAX_W = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H = DEF_MAX_HEIGHT;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT = 20000;

    // One filtered pixel as it leaves the block
    typedef struct packed {
        logic       bit_pixel;
        logic [6:0] row;
        logic [6:0] column;
        logic       eof;
    } t_pix_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] pixel_value
    logic        s_tuser = 1'b0; // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [0] bit_pixel, [7:1] out_row, [14:8] out_column
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    binarize_isolated_pixel_removal dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Filter state mirrored by the predictor
    logic        upper_bits [MAX_W];
    logic        middle_bits [MAX_W];
    logic [7:0]  thr_reg = RST_THRESHOLD;
    logic [7:0]  width_reg = RST_WIDTH;
    logic [7:0]  height_reg = RST_HEIGHT;
    int unsigned in_row = 0;
    int unsigned in_col = 0;
    int unsigned out_pos = 0;
    int unsigned undecided = 0;
    logic        staged_valid = 1'b0;
    logic        staged_bit = 1'b0;
    int unsigned staged_pos = 0;

    t_pix_result expected_pixels [$];

    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_req = 0;
    int unsigned hold_off_len = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    initial begin
        for (int i = 0; i < MAX_W; i++) begin
            upper_bits[i] = 1'b0;
            middle_bits[i] = 1'b0;
        end
    end

    // Free-running clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("binarize_isolated_pixel_removal verification failed");
        $finish;
    end

    function automatic int unsigned active_width();
        if (width_reg < MIN_SIDE) return MIN_SIDE;
        if (width_reg > MAX_W) return MAX_W;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg < MIN_SIDE) return MIN_SIDE;
        if (height_reg > MAX_H) return MAX_H;
        return height_reg;
    endfunction

    function automatic void restart_positions();
        in_row = 0;
        in_col = 0;
        out_pos = 0;
        undecided = 0;
        staged_valid = 1'b0;
        staged_bit = 1'b0;
        staged_pos = 0;
    endfunction

    // Queue the staged pixel as the next expected word
    function automatic void release_staged();
        int unsigned w;
        t_pix_result r;
        w = active_width();
        r.bit_pixel = staged_bit;
        r.row = 7'(staged_pos / w);
        r.column = 7'(staged_pos % w);
        r.eof = (staged_pos == w * active_height() - 1);
        expected_pixels.push_back(r);
    endfunction

    // Decide the pixel at out_pos from its cross neighbors
    function automatic logic judge_pixel(logic below);
        int unsigned w, h, r, c;
        logic up, ctr, lf, rt, dn;
        w = active_width();
        h = active_height();
        r = out_pos / w;
        c = (out_pos % w) % MAX_W;
        up = (r > 0) ? upper_bits[c] : 1'b0;
        ctr = middle_bits[c];
        lf = 1'b0;
        rt = 1'b0;
        if (c > 0) lf = (undecided >= w) ? upper_bits[c - 1] : middle_bits[c - 1];
        if (c + 1 < w) rt = middle_bits[c + 1];
        dn = (r + 1 < h) ? below : 1'b0;
        out_pos = (out_pos + 1 >= w * h) ? 0 : out_pos + 1;
        return ctr & (up | dn | lf | rt);
    endfunction

    // Stage a fresh decision, pushing out the previous one
    function automatic void stage_pixel(logic v, int unsigned pos);
        if (staged_valid) release_staged();
        staged_valid = 1'b1;
        staged_bit = v;
        staged_pos = pos;
    endfunction

    // Advance the predictor by one accepted input word
    function automatic void filter_word(logic cmd, logic [7:0] grey);
        int unsigned w, h, col, pos;
        logic b, v;
        w = active_width();
        h = active_height();
        if (cmd == CMD_PIXEL) begin
            b = (grey > thr_reg);
            col = in_col % MAX_W;
            if (undecided >= w) begin
                pos = out_pos;
                v = judge_pixel(b);
                stage_pixel(v, pos);
            end else begin
                undecided++;
            end
            upper_bits[col] = middle_bits[col];
            middle_bits[col] = b;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) in_row = 0;
            end
        end else if (undecided > 0 && in_row == 0 && out_pos / w == h - 1) begin
            pos = out_pos;
            v = judge_pixel(1'b0);
            undecided--;
            stage_pixel(v, pos);
        end else if (staged_valid) begin
            release_staged();
            staged_valid = 1'b0;
        end
    endfunction

    function automatic void filter_config(logic [1:0] idx, logic [7:0] val);
        case (idx)
            REG_THRESHOLD: thr_reg = val;
            REG_WIDTH: begin
                width_reg = val;
                restart_positions();
            end
            REG_HEIGHT: begin
                height_reg = val;
                restart_positions();
            end
            default: ;
        endcase
    endfunction

    // Grey level that lands on the wanted side of the threshold
    function automatic logic [7:0] grey_for(logic white);
        if (!white) return 8'($urandom_range(0, thr_reg));
        if (thr_reg == 8'd255) return 8'd255;
        return 8'($urandom_range(thr_reg + 1, 255));
    endfunction

    // Receiver: random ready, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_req != hold_seen) begin
            hold_seen = hold_off_req;
            hold_left = hold_off_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each output word with the oldest expectation
    always @(posedge i_clk) begin
        t_pix_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("output word with nothing expected: tdata %h tlast %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[0] !== want.bit_pixel) begin
                    $error("bit_pixel: expected %0d, actual %0d", want.bit_pixel, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[7:1] !== want.row) begin
                    $error("out_row: expected %0d, actual %0d", want.row, m_tdata[7:1]);
                    fail_count++;
                end
                if (m_tdata[14:8] !== want.column) begin
                    $error("out_column: expected %0d, actual %0d", want.column, m_tdata[14:8]);
                    fail_count++;
                end
                if (m_tlast !== want.eof) begin
                    $error("end_of_frame: expected %0d, actual %0d", want.eof, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic cmd, input logic [7:0] grey);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= grey;
        s_tuser <= cmd;
        do @(posedge i_clk); while (!s_tready);
        filter_word(cmd, grey);
        words_sent++;
    endtask

    task automatic send_drains(input int unsigned n);
        repeat (n) send_word(CMD_DRAIN, 8'($urandom_range(255)));
    endtask

    // Send pixels of a given white density, with optional stray drains
    task automatic send_frame(input int unsigned npix, input int unsigned density,
                              input int unsigned noise_pct);
        repeat (npix) begin
            if ($urandom_range(99) < noise_pct) send_word(CMD_DRAIN, 8'($urandom_range(255)));
            send_word(CMD_PIXEL, grey_for($urandom_range(99) < density));
        end
    endtask

    // Hold the input until every expected word has arrived, then settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        logic [31:0] word;
        word = $urandom();
        word[7:0] = val;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        filter_config(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [7:0] want, input string name);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, prdata[7:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Defaults after reset; a few words at full frame size yield nothing
    task automatic test_reset_defaults();
        check_reg(REG_THRESHOLD, RST_THRESHOLD, "threshold");
        check_reg(REG_WIDTH, RST_WIDTH, "frame_width");
        check_reg(REG_HEIGHT, RST_HEIGHT, "frame_height");
        send_word(CMD_PIXEL, 8'd0);
        send_word(CMD_PIXEL, 8'd255);
        send_word(CMD_PIXEL, 8'd129);
        send_drains(1);
        wait_idle();
    endtask

    // Write an unknown index (ignored) and undersized sides, which read back raw but clamp to the minimum
    task automatic test_register_access();
        write_reg(REG_UNUSED, 8'($urandom_range(255)));
        write_reg(REG_THRESHOLD, 8'd100);
        write_reg(REG_WIDTH, 8'd0);
        write_reg(REG_HEIGHT, 8'd2);
        check_reg(REG_THRESHOLD, 8'd100, "threshold");
        check_reg(REG_WIDTH, 8'd0, "frame_width");
        check_reg(REG_HEIGHT, 8'd2, "frame_height");
    endtask

    // Isolated corners and center get cleared; a vertical pair survives
    task automatic test_isolated_pixels();
        logic [7:0] lone [9] = '{8'd101, 8'd100, 8'd0, 8'd99, 8'd255, 8'd100,
                                 8'd0, 8'd0, 8'd255};
        logic [7:0] pair [9] = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd101, 8'd0,
                                 8'd0, 8'd0, 8'd0};
        for (int i = 0; i < 9; i++) begin
            send_word(CMD_PIXEL, lone[i]);
            // drain in mid-frame only releases the staged pixel
            if (i == 4) send_drains(1);
        end
        // next frame pushes the previous one out directly
        for (int i = 0; i < 9; i++) send_word(CMD_PIXEL, pair[i]);
        send_drains(5);
        wait_idle();
    endtask

    // Widest and tallest frames, sizes given out of range
    task automatic test_size_extremes();
        write_reg(REG_THRESHOLD, 8'd0);
        write_reg(REG_WIDTH, 8'd255);
        write_reg(REG_HEIGHT, 8'd1);
        send_frame(active_width() * active_height(), 60, 0);
        send_drains(active_width() + 1);
        wait_idle();
        write_reg(REG_THRESHOLD, 8'd255);
        write_reg(REG_WIDTH, 8'd3);
        write_reg(REG_HEIGHT, 8'd200);
        send_frame(active_width() * active_height(), 50, 0);
        send_drains(active_width() + 1);
        wait_idle();
    endtask

    // Stall the receiver while input keeps coming, then pause the sender
    task automatic test_backpressure();
        write_reg(REG_THRESHOLD, 8'd90);
        write_reg(REG_WIDTH, 8'd8);
        write_reg(REG_HEIGHT, 8'd5);
        hold_off_len = 150;
        hold_off_req++;
        send_frame(40, 50, 0);
        wait_idle();
        send_frame(40, 35, 0);
        send_drains(9);
        wait_idle();
    endtask

    // Random frames, mostly well formed, some cut short, some noise
    task automatic test_random_streams(input int unsigned n);
        int unsigned start, kind, sel, noise;
        logic [7:0] wv, hv;
        start = words_sent;
        while (words_sent - start < n) begin
            wait_idle();
            sel = $urandom_range(99);
            if (sel < 10) write_reg(REG_THRESHOLD, 8'd0);
            else if (sel < 20) write_reg(REG_THRESHOLD, 8'd255);
            else if (sel < 60) write_reg(REG_THRESHOLD, 8'($urandom_range(255)));
            sel = $urandom_range(99);
            if (sel < 6) begin
                wv = $urandom_range(1) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(129, 255));
                hv = 8'd3;
            end else if (sel < 12) begin
                wv = 8'd3;
                hv = $urandom_range(1) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(129, 255));
            end else begin
                wv = 8'($urandom_range(3, 12));
                hv = 8'($urandom_range(3, 8));
            end
            write_reg(REG_WIDTH, wv);
            write_reg(REG_HEIGHT, hv);
            kind = $urandom_range(99);
            noise = ($urandom_range(9) == 0) ? 5 : 0;
            if (kind < 70) begin
                repeat ($urandom_range(1, 3))
                    send_frame(active_width() * active_height(), $urandom_range(5, 95), noise);
                send_drains(active_width() + 1 + $urandom_range(0, 2));
            end else if (kind < 85) begin
                send_frame($urandom_range(1, active_width() * active_height() - 1),
                           $urandom_range(5, 95), noise);
                if ($urandom_range(1)) send_drains($urandom_range(1, 3));
            end else begin
                repeat (15) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
        wait_idle();
    endtask

    // Test sequence
    initial begin
        int unsigned spin;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 37;
        recv_idle_pct = 50;
        test_reset_defaults();
        test_register_access();
        test_isolated_pixels();
        test_size_extremes();
        test_backpressure();
        test_random_streams(80);

        send_idle_pct = 50;
        recv_idle_pct = 37;
        test_random_streams(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_streams(80);

        // drain whatever is still due, bounded
        s_tvalid <= 1'b0;
        spin = 0;
        while (expected_pixels.size() > 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_pixels.size() > 0) begin
            $error("%0d expected output words never arrived", expected_pixels.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("binarize_isolated_pixel_removal verification clean");
        end else begin
            $display("binarize_isolated_pixel_removal verification failed");
        end
        $finish;
    end

endmodule
